FILE: hdl/vau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vau_pkg: shared types and constants of the vector arithmetic unit
// field widths, command codes and the beat formats handed between cells
// ----------------------------------------------------------------------------
package vau_pkg;

    localparam int FIELD_W        = 32;
    localparam int CMD_W          = 3;
    localparam int LANES          = 3;
    localparam int NMUL           = 6;
    localparam int SQ_W           = 2 * FIELD_W;
    localparam int ROOT_W         = FIELD_W;
    localparam int SQ_REM_W       = FIELD_W + 2;
    localparam int DIV_REM_W      = FIELD_W + 1;
    localparam int WIDE_W         = 2 * FIELD_W + 2;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_BITS_DEF  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_SCALE = 3'd2,
        CMD_DOT   = 3'd3,
        CMD_CROSS = 3'd4,
        CMD_MAG   = 3'd5,
        CMD_NORM  = 3'd6,
        CMD_EQUAL = 3'd7
    } cmd_t;

    // result fields carried along the cell chains
    typedef struct packed {
        cmd_t                           cmd;
        logic [LANES-1:0]               neg;
        logic [LANES-1:0][FIELD_W-1:0]  vec;
        logic [FIELD_W-1:0]             scalar;
        logic                           clip;
    } carry_t;

    typedef struct packed {
        logic                   valid;
        carry_t                 c;
        logic [SQ_W-1:0]        x;
        logic [SQ_REM_W-1:0]    rem;
        logic [ROOT_W-1:0]      root;
    } sq_stage_t;

    typedef struct packed {
        logic                               valid;
        carry_t                             c;
        logic [ROOT_W-1:0]                  m;
        logic [LANES-1:0][DIV_REM_W-1:0]    rem;
    } div_stage_t;

endpackage
`default_nettype wire

FILE: hdl/vau_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vau_sqrt_cell: one root bit of the square root chain
// takes two radicand bits, tries the next root bit, registers the beat
// ----------------------------------------------------------------------------
module vau_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  vau_pkg::sq_stage_t  stage_in,
    output vau_pkg::sq_stage_t  stage_out
);
    import vau_pkg::*;

    logic                   vld_reg;
    sq_stage_t              pay_reg;
    sq_stage_t              stage_next;
    logic [SQ_REM_W+1:0]    rem_sh;
    logic [SQ_REM_W+1:0]    trial;

    always_comb
    begin
        rem_sh     = {stage_in.rem, stage_in.x[SQ_W-1 -: 2]};
        trial      = {2'b00, stage_in.root, 2'b01};
        stage_next = stage_in;
        stage_next.x = {stage_in.x[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            stage_next.rem  = SQ_REM_W'(rem_sh - trial);
            stage_next.root = {stage_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            stage_next.rem  = rem_sh[SQ_REM_W-1:0];
            stage_next.root = {stage_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pay_reg <= stage_next;
    end

    always_comb
    begin
        stage_out       = pay_reg;
        stage_out.valid = vld_reg;
    end

endmodule
`default_nettype wire

FILE: hdl/vau_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vau_div_cell: one quotient bit of the normalize divider, three lanes
// compare and subtract the magnitude, shift the partial remainder
// ----------------------------------------------------------------------------
module vau_div_cell #(
    parameter int QW = vau_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  vau_pkg::div_stage_t                     stage_in,
    input  logic [vau_pkg::LANES-1:0][QW-1:0]       quo_in,
    output vau_pkg::div_stage_t                     stage_out,
    output logic [vau_pkg::LANES-1:0][QW-1:0]       quo_out
);
    import vau_pkg::*;

    logic                           vld_reg;
    div_stage_t                     pay_reg;
    logic [LANES-1:0][QW-1:0]       quo_reg;
    div_stage_t                     stage_next;
    logic [LANES-1:0][QW-1:0]       quo_next;
    logic [LANES-1:0][DIV_REM_W-1:0] part;
    logic [LANES-1:0]               qbit;

    always_comb
    begin
        stage_next = stage_in;
        for (int l = 0; l < LANES; l++)
        begin
            qbit[l] = (stage_in.rem[l] >= {1'b0, stage_in.m});
            part[l] = qbit[l] ? (stage_in.rem[l] - {1'b0, stage_in.m}) : stage_in.rem[l];
            stage_next.rem[l] = {part[l][FIELD_W-1:0], 1'b0};
            quo_next[l] = {quo_in[l][QW-2:0], qbit[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= stage_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        stage_out       = pay_reg;
        stage_out.valid = vld_reg;
    end

    assign quo_out = quo_reg;

endmodule
`default_nettype wire

FILE: hdl/vector3_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_arith_unit: three-component fixed-point vector ALU
// add, sub, scale, dot, cross, magnitude, normalize and equality on signed
// fixed-point vectors, saturated results, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel | handshake             | beat contents
//  --------+-----------------------+---------------------------------------
//  input   | in_valid / in_stall   | cmd, ax ay az, bx by bz, factor
//  output  | out_valid / out_stall | rx ry rz, scalar_out, saturated
//
//  one beat per cycle in and out while no stall holds the pipe; the stages
//  are input reg, multiply, combine, 32 square root cells, FRAC_BITS + 1
//  divider cells and output reg, set by the bit-per-cell root and quotient
//  rst_n clears only the valid bits of the stages
//  a stalled output beat freezes the pipe only when the last cell is full;
//  bubbles in front of it keep draining, in_stall follows from that
//
module vector3_arith_unit #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = vau_pkg::WORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [vau_pkg::CMD_W-1:0]           cmd,
    input  logic signed [vau_pkg::FIELD_W-1:0]  ax,
    input  logic signed [vau_pkg::FIELD_W-1:0]  ay,
    input  logic signed [vau_pkg::FIELD_W-1:0]  az,
    input  logic signed [vau_pkg::FIELD_W-1:0]  bx,
    input  logic signed [vau_pkg::FIELD_W-1:0]  by,
    input  logic signed [vau_pkg::FIELD_W-1:0]  bz,
    input  logic signed [vau_pkg::FIELD_W-1:0]  factor,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vau_pkg::FIELD_W-1:0]  rx,
    output logic signed [vau_pkg::FIELD_W-1:0]  ry,
    output logic signed [vau_pkg::FIELD_W-1:0]  rz,
    output logic signed [vau_pkg::FIELD_W-1:0]  scalar_out,
    output logic                                saturated
);
    import vau_pkg::*;

    localparam int QW    = FRAC_BITS + 1;   // quotient never exceeds one
    localparam int NDIV  = QW;
    localparam int NSQRT = ROOT_W;
    localparam logic signed [WIDE_W-1:0] SAT_HI =
        $signed((WIDE_W'(1) << (WORD_BITS - 1)) - WIDE_W'(1));
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - $signed(WIDE_W'(1));

    // clamp to the word range, return {clip, low field bits}
    function automatic logic [FIELD_W:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        logic                     clip;
        t    = v;
        clip = 1'b0;
        if (v > SAT_HI)
        begin
            t    = SAT_HI;
            clip = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            t    = SAT_LO;
            clip = 1'b1;
        end
        return {clip, t[FIELD_W-1:0]};
    endfunction

    // pipe advance: hold only when a full last cell meets a stalled beat
    logic adv;

    // input register
    logic                       s0_vld_reg;
    cmd_t                       s0_cmd_reg;
    logic signed [FIELD_W-1:0]  s0_a_reg [LANES];
    logic signed [FIELD_W-1:0]  s0_b_reg [LANES];
    logic signed [FIELD_W-1:0]  s0_f_reg;

    // multiply stage
    logic signed [FIELD_W-1:0]  mx [NMUL];
    logic signed [FIELD_W-1:0]  my [NMUL];
    logic signed [SQ_W-1:0]     s1_p_next [NMUL];
    logic signed [FIELD_W:0]    s1_sum_next [LANES];
    logic [FIELD_W-1:0]         s1_abs_next [LANES];
    logic                       s1_vld_reg;
    cmd_t                       s1_cmd_reg;
    logic signed [SQ_W-1:0]     s1_p_reg [NMUL];
    logic signed [FIELD_W:0]    s1_sum_reg [LANES];
    logic [FIELD_W-1:0]         s1_abs_reg [LANES];
    logic [LANES-1:0]           s1_neg_reg;
    logic                       s1_eq_reg;

    // combine stage
    logic signed [WIDE_W-1:0]   pw [NMUL];
    logic signed [WIDE_W-1:0]   sum3;
    logic signed [WIDE_W-1:0]   vw [LANES];
    logic signed [WIDE_W-1:0]   sw;
    logic                       is_vec;
    logic [FIELD_W:0]           sat_v [LANES];
    logic [FIELD_W:0]           sat_s;
    sq_stage_t                  s2_next;
    logic                       s2_vld_reg;
    sq_stage_t                  s2_pay_reg;

    // cell chains
    sq_stage_t                  sq_s  [NSQRT+1];
    div_stage_t                 div_s [NDIV+1];
    logic [LANES-1:0][QW-1:0]   quo_s [NDIV+1];

    // output stage
    carry_t                     fin;
    logic signed [WIDE_W-1:0]   qw_s [LANES];
    logic [FIELD_W:0]           fin_v [LANES];
    logic [FIELD_W:0]           fin_m;
    logic                       out_vld_reg;
    logic [FIELD_W-1:0]         rx_reg;
    logic [FIELD_W-1:0]         ry_reg;
    logic [FIELD_W-1:0]         rz_reg;
    logic [FIELD_W-1:0]         scalar_reg;
    logic                       sat_reg;

    assign adv      = !out_vld_reg || !out_stall || !div_s[NDIV].valid;
    assign in_stall = !adv;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (adv)
            s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_cmd_reg  <= cmd_t'(cmd);
            s0_a_reg[0] <= ax;
            s0_a_reg[1] <= ay;
            s0_a_reg[2] <= az;
            s0_b_reg[0] <= bx;
            s0_b_reg[1] <= by;
            s0_b_reg[2] <= bz;
            s0_f_reg    <= factor;
        end
    end

    // ---------------- multiply stage ----------------
    // six shared multipliers, operands steered by command
    always_comb
    begin
        for (int j = 0; j < NMUL; j++)
        begin
            mx[j] = '0;
            my[j] = '0;
        end
        unique case (s0_cmd_reg)
            CMD_SCALE:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    mx[l] = s0_a_reg[l];
                    my[l] = s0_f_reg;
                end
            end
            CMD_DOT:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    mx[l] = s0_a_reg[l];
                    my[l] = s0_b_reg[l];
                end
            end
            CMD_CROSS:
            begin
                // positive terms in 0..2, negative terms in 3..5
                mx[0] = s0_a_reg[1]; my[0] = s0_b_reg[2];
                mx[1] = s0_a_reg[2]; my[1] = s0_b_reg[0];
                mx[2] = s0_a_reg[0]; my[2] = s0_b_reg[1];
                mx[3] = s0_a_reg[2]; my[3] = s0_b_reg[1];
                mx[4] = s0_a_reg[0]; my[4] = s0_b_reg[2];
                mx[5] = s0_a_reg[1]; my[5] = s0_b_reg[0];
            end
            CMD_MAG, CMD_NORM:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    mx[l] = s0_a_reg[l];
                    my[l] = s0_a_reg[l];
                end
            end
            CMD_ADD, CMD_SUB, CMD_EQUAL:
            begin
            end
        endcase
        for (int j = 0; j < NMUL; j++)
            s1_p_next[j] = mx[j] * my[j];
        for (int l = 0; l < LANES; l++)
        begin
            s1_sum_next[l] = (s0_cmd_reg == CMD_SUB) ? s0_a_reg[l] - s0_b_reg[l]
                                                     : s0_a_reg[l] + s0_b_reg[l];
            s1_abs_next[l] = s0_a_reg[l][FIELD_W-1] ? FIELD_W'(-s0_a_reg[l])
                                                    : FIELD_W'(s0_a_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= s0_cmd_reg;
            s1_p_reg   <= s1_p_next;
            s1_sum_reg <= s1_sum_next;
            s1_abs_reg <= s1_abs_next;
            for (int l = 0; l < LANES; l++)
                s1_neg_reg[l] <= s0_a_reg[l][FIELD_W-1];
            s1_eq_reg  <= (s0_a_reg[0] == s0_b_reg[0]) && (s0_a_reg[1] == s0_b_reg[1]) &&
                          (s0_a_reg[2] == s0_b_reg[2]);
        end
    end

    // ---------------- combine stage ----------------
    // exact sums of products, one floor rescale, then saturate
    always_comb
    begin
        for (int j = 0; j < NMUL; j++)
            pw[j] = WIDE_W'(s1_p_reg[j]);
        sum3   = pw[0] + pw[1] + pw[2];
        sw     = '0;
        is_vec = 1'b1;
        for (int l = 0; l < LANES; l++)
            vw[l] = '0;
        unique case (s1_cmd_reg)
            CMD_ADD, CMD_SUB:
            begin
                for (int l = 0; l < LANES; l++)
                    vw[l] = WIDE_W'(s1_sum_reg[l]);
            end
            CMD_SCALE:
            begin
                for (int l = 0; l < LANES; l++)
                    vw[l] = pw[l] >>> FRAC_BITS;
            end
            CMD_DOT:
            begin
                is_vec = 1'b0;
                sw     = sum3 >>> FRAC_BITS;
            end
            CMD_CROSS:
            begin
                for (int l = 0; l < LANES; l++)
                    vw[l] = (pw[l] - pw[l+LANES]) >>> FRAC_BITS;
            end
            CMD_MAG, CMD_NORM:
            begin
                is_vec = 1'b0;
            end
            CMD_EQUAL:
            begin
                is_vec = 1'b0;
                sw     = $signed(WIDE_W'(s1_eq_reg));
            end
        endcase

        for (int l = 0; l < LANES; l++)
            sat_v[l] = sat_word(vw[l]);
        sat_s = sat_word(sw);

        s2_next          = '0;
        s2_next.valid    = s1_vld_reg;
        s2_next.c.cmd    = s1_cmd_reg;
        if ((s1_cmd_reg == CMD_MAG) || (s1_cmd_reg == CMD_NORM))
        begin
            // root and divider work on |a|, signs ride along
            s2_next.x     = sum3[SQ_W-1:0];
            s2_next.c.neg = s1_neg_reg;
            for (int l = 0; l < LANES; l++)
                s2_next.c.vec[l] = s1_abs_reg[l];
        end
        else if (is_vec)
        begin
            for (int l = 0; l < LANES; l++)
                s2_next.c.vec[l] = sat_v[l][FIELD_W-1:0];
            s2_next.c.clip = sat_v[0][FIELD_W] | sat_v[1][FIELD_W] | sat_v[2][FIELD_W];
        end
        else
        begin
            s2_next.c.scalar = sat_s[FIELD_W-1:0];
            s2_next.c.clip   = sat_s[FIELD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_pay_reg <= s2_next;
    end

    always_comb
    begin
        sq_s[0]       = s2_pay_reg;
        sq_s[0].valid = s2_vld_reg;
    end

    // ---------------- square root chain ----------------
    for (genvar k = 0; k < NSQRT; k++)
    begin : g_sqrt
        vau_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage_in  (sq_s[k]),
            .stage_out (sq_s[k+1])
        );
    end

    // floor root becomes the divisor, |a| the starting remainder
    always_comb
    begin
        div_s[0].valid = sq_s[NSQRT].valid;
        div_s[0].c     = sq_s[NSQRT].c;
        div_s[0].m     = sq_s[NSQRT].root;
        for (int l = 0; l < LANES; l++)
            div_s[0].rem[l] = {1'b0, sq_s[NSQRT].c.vec[l]};
        quo_s[0] = '0;
    end

    // ---------------- divider chain ----------------
    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        vau_div_cell #(
            .QW (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage_in  (div_s[k]),
            .quo_in    (quo_s[k]),
            .stage_out (div_s[k+1]),
            .quo_out   (quo_s[k+1])
        );
    end

    // ---------------- output stage ----------------
    always_comb
    begin
        fin   = div_s[NDIV].c;
        fin_m = sat_word($signed(WIDE_W'(div_s[NDIV].m)));
        for (int l = 0; l < LANES; l++)
        begin
            qw_s[l]  = div_s[NDIV].c.neg[l] ? -$signed(WIDE_W'(quo_s[NDIV][l]))
                                            : $signed(WIDE_W'(quo_s[NDIV][l]));
            fin_v[l] = sat_word(qw_s[l]);
        end
        unique case (div_s[NDIV].c.cmd)
            CMD_MAG:
            begin
                fin.vec    = '0;
                fin.scalar = fin_m[FIELD_W-1:0];
                fin.clip   = fin_m[FIELD_W];
            end
            CMD_NORM:
            begin
                fin.scalar = '0;
                fin.vec    = '0;
                fin.clip   = 1'b0;
                // zero vector stays zero
                if (div_s[NDIV].m != '0)
                begin
                    for (int l = 0; l < LANES; l++)
                        fin.vec[l] = fin_v[l][FIELD_W-1:0];
                    fin.clip = fin_v[0][FIELD_W] | fin_v[1][FIELD_W] | fin_v[2][FIELD_W];
                end
            end
            CMD_ADD, CMD_SUB, CMD_SCALE, CMD_DOT, CMD_CROSS, CMD_EQUAL:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (!out_vld_reg || !out_stall)
            out_vld_reg <= div_s[NDIV].valid;
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || !out_stall)
        begin
            rx_reg     <= fin.vec[0];
            ry_reg     <= fin.vec[1];
            rz_reg     <= fin.vec[2];
            scalar_reg <= fin.scalar;
            sat_reg    <= fin.clip;
        end
    end

    assign out_valid  = out_vld_reg;
    assign rx         = $signed(rx_reg);
    assign ry         = $signed(ry_reg);
    assign rz         = $signed(rz_reg);
    assign scalar_out = $signed(scalar_reg);
    assign saturated  = sat_reg;

`ifndef SYNTHESIS
    // input only held back by a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked output beat");

    // vector and scalar results never both nonzero
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((scalar_out == '0) || ((rx == '0) && (ry == '0) && (rz == '0))))
        else $error("vector and scalar result both set");

    // floor root bounds every component magnitude
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_s[NSQRT].valid && ((sq_s[NSQRT].c.cmd == CMD_MAG) ||
                               (sq_s[NSQRT].c.cmd == CMD_NORM)))
        |-> ((sq_s[NSQRT].root >= sq_s[NSQRT].c.vec[0]) &&
             (sq_s[NSQRT].root >= sq_s[NSQRT].c.vec[1]) &&
             (sq_s[NSQRT].root >= sq_s[NSQRT].c.vec[2])))
        else $error("square root below a component");

    // normalized components never exceed one
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (div_s[NDIV].valid && (div_s[NDIV].c.cmd == CMD_NORM) && (div_s[NDIV].m != '0))
        |-> ((quo_s[NDIV][0] <= (QW'(1) << FRAC_BITS)) &&
             (quo_s[NDIV][1] <= (QW'(1) << FRAC_BITS)) &&
             (quo_s[NDIV][2] <= (QW'(1) << FRAC_BITS))))
        else $error("normalize quotient out of range");
`endif

endmodule
`default_nettype wire
